/* rtl/uabt_pkg.sv */
package uabt_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PERIOD_W = 16;

  // Defaults for the top-level parameters and registers
  localparam int unsigned DATA_BITS_DEF = 8;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;
  localparam logic [PERIOD_W-1:0] COUNT_MAX    = 16'hFFFF;

  // Timing info from the baud unit to the transmitter and receiver
  typedef struct packed {
    logic [PERIOD_W-1:0] period;     // effective bit period this tick
    logic [PERIOD_W-1:0] half;       // period / 2
    logic                meas_busy;  // measurement armed or counting
  } baud_ctl_t;

endpackage

/* rtl/uart_8n1_autobaud_transceiver_unit.sv */
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   rx_line_i, send_valid_i, send_byte_i, measure_baud_i
// out      out_valid_o / out_ready_i tx_line_o, tx_busy_o, rx_valid_o, rx_byte_o,
//                                    baud_valid_o, baud_period_o
// cfg      cfg_we_i                  cfg_wdata_i (default bit period)
//
// One item (one tick) per cycle while out_ready_i is high; an accepted item passes
// through the input register and then the result register.
// All tick state advances in the cycle an item moves from the input register
// into the result register.
// Reset clears the valid flags and the tick state and loads the default bit period with 104.
// A stalled result holds; the input register still takes one more item, then
// in_ready_o follows out_ready_i.
module uart_8n1_autobaud_transceiver_unit #(
  parameter int unsigned DATA_BITS = uabt_pkg::DATA_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uabt_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          rx_line_i,
  input  logic                          send_valid_i,
  input  logic [uabt_pkg::BYTE_W-1:0]   send_byte_i,
  input  logic                          measure_baud_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          tx_line_o,
  output logic                          tx_busy_o,
  output logic                          rx_valid_o,
  output logic [uabt_pkg::BYTE_W-1:0]   rx_byte_o,
  output logic                          baud_valid_o,
  output logic [uabt_pkg::PERIOD_W-1:0] baud_period_o
);

  logic                          in_vld_q;
  logic                          rx_line_q, send_valid_q, measure_q;
  logic [uabt_pkg::BYTE_W-1:0]   send_byte_q;
  logic                          step;
  logic                          out_vld_q;
  uabt_pkg::baud_ctl_t           ctl;
  logic                          tx_line_d, tx_busy_d, rx_valid_d, baud_valid_d;
  logic [uabt_pkg::BYTE_W-1:0]   rx_byte_d;
  logic                          tx_line_q, tx_busy_q, rx_valid_q, baud_valid_q;
  logic [uabt_pkg::BYTE_W-1:0]   rx_byte_q;
  logic [uabt_pkg::PERIOD_W-1:0] period_q;

  // Pipeline control
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (step)             out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_line_q    <= rx_line_i;
      send_valid_q <= send_valid_i;
      send_byte_q  <= send_byte_i;
      measure_q    <= measure_baud_i;
    end
  end

  uabt_baud u_baud (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_line_i      (rx_line_q),
    .measure_baud_i (measure_q),
    .ctl_o          (ctl),
    .baud_valid_o   (baud_valid_d)
  );

  uabt_tx #(.DATA_BITS(DATA_BITS)) u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .ctl_i        (ctl),
    .send_valid_i (send_valid_q),
    .send_byte_i  (send_byte_q),
    .tx_line_o    (tx_line_d),
    .tx_busy_o    (tx_busy_d)
  );

  uabt_rx #(.DATA_BITS(DATA_BITS)) u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ctl_i      (ctl),
    .rx_line_i  (rx_line_q),
    .rx_valid_o (rx_valid_d),
    .rx_byte_o  (rx_byte_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      tx_line_q    <= tx_line_d;
      tx_busy_q    <= tx_busy_d;
      rx_valid_q   <= rx_valid_d;
      rx_byte_q    <= rx_byte_d;
      baud_valid_q <= baud_valid_d;
      period_q     <= ctl.period;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign tx_line_o     = tx_line_q;
  assign tx_busy_o     = tx_busy_q;
  assign rx_valid_o    = rx_valid_q;
  assign rx_byte_o     = rx_byte_q;
  assign baud_valid_o  = baud_valid_q;
  assign baud_period_o = period_q;

  // Checks
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o) else $error("input register empty but not ready");

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q) else $error("tick step produced no result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> out_vld_q) else $error("stalled result dropped");

  a_period_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (period_q >= uabt_pkg::PERIOD_MIN)) else $error("period below minimum");

  a_rx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rx_valid_q) |-> (rx_byte_q == '0)) else $error("rx byte without valid");

endmodule

/* rtl/uabt_baud.sv */
module uabt_baud (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          cfg_we_i,
  input  logic [uabt_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input  logic                          rx_line_i,
  input  logic                          measure_baud_i,
  output uabt_pkg::baud_ctl_t           ctl_o,
  output logic                          baud_valid_o
);

  localparam logic [1:0] MEAS_IDLE  = 2'd0;
  localparam logic [1:0] MEAS_ARMED = 2'd1;
  localparam logic [1:0] MEAS_COUNT = 2'd2;

  logic [1:0]                   meas_phase_q, meas_phase_d;
  logic [uabt_pkg::PERIOD_W-1:0] meas_cnt_q, meas_cnt_d;
  logic [uabt_pkg::PERIOD_W-1:0] measured_q, measured_d;
  logic                         have_q, have_d;
  logic [uabt_pkg::PERIOD_W-1:0] default_q;
  logic [uabt_pkg::PERIOD_W-1:0] period_raw;
  logic [uabt_pkg::PERIOD_W-1:0] period;

  // Measurement sequencer
  always_comb begin
    meas_phase_d = meas_phase_q;
    meas_cnt_d   = meas_cnt_q;
    measured_d   = measured_q;
    have_d       = have_q;
    baud_valid_o = 1'b0;
    unique case (meas_phase_q)
      MEAS_IDLE: begin
        if (measure_baud_i) meas_phase_d = MEAS_ARMED;
      end
      MEAS_ARMED: begin
        if (!rx_line_i) begin
          meas_phase_d = MEAS_COUNT;
          meas_cnt_d   = uabt_pkg::PERIOD_W'(1);
        end
      end
      MEAS_COUNT: begin
        if (!rx_line_i) begin
          if (meas_cnt_q != uabt_pkg::COUNT_MAX) meas_cnt_d = meas_cnt_q + 1'b1;
        end else begin
          measured_d   = meas_cnt_q;
          have_d       = 1'b1;
          meas_phase_d = MEAS_IDLE;
          baud_valid_o = 1'b1;
        end
      end
      default: meas_phase_d = MEAS_IDLE;
    endcase
  end

  // Effective period after this tick's update, clamped to the minimum
  assign period_raw = have_d ? measured_d : default_q;
  assign period     = (period_raw < uabt_pkg::PERIOD_MIN) ? uabt_pkg::PERIOD_MIN : period_raw;

  assign ctl_o.period    = period;
  assign ctl_o.half      = period >> 1;
  assign ctl_o.meas_busy = (meas_phase_d != MEAS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_phase_q <= MEAS_IDLE;
      meas_cnt_q   <= '0;
      measured_q   <= '0;
      have_q       <= 1'b0;
      default_q    <= uabt_pkg::PERIOD_RESET;
    end else begin
      if (step_i) begin
        meas_phase_q <= meas_phase_d;
        meas_cnt_q   <= meas_cnt_d;
        measured_q   <= measured_d;
        have_q       <= have_d;
      end
      if (cfg_we_i) default_q <= cfg_wdata_i;
    end
  end

endmodule

/* rtl/uabt_tx.sv */
module uabt_tx #(
  parameter int unsigned DATA_BITS = uabt_pkg::DATA_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  uabt_pkg::baud_ctl_t         ctl_i,
  input  logic                        send_valid_i,
  input  logic [uabt_pkg::BYTE_W-1:0] send_byte_i,
  output logic                        tx_line_o,
  output logic                        tx_busy_o
);

  localparam int unsigned PW = $clog2(DATA_BITS + 3);
  localparam logic [PW-1:0] PH_IDLE  = PW'(0);
  localparam logic [PW-1:0] PH_START = PW'(1);
  localparam logic [PW-1:0] PH_DATA0 = PW'(2);
  localparam logic [PW-1:0] PH_DLAST = PW'(DATA_BITS + 1);
  localparam logic [PW-1:0] PH_STOP  = PW'(DATA_BITS + 2);

  logic [PW-1:0]                   phase_q, phase_d, phase_inc;
  logic [uabt_pkg::BYTE_W-1:0]     shift_q, shift_d;
  logic [uabt_pkg::PERIOD_W-1:0]   cnt_q, cnt_d, cnt_inc;

  assign cnt_inc   = cnt_q + 1'b1;
  assign phase_inc = phase_q + 1'b1;

  // Frame sequencer: start, data bits, stop, one period each
  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    if (phase_q == PH_IDLE) begin
      if (send_valid_i) begin
        shift_d = send_byte_i;
        phase_d = PH_START;
        cnt_d   = '0;
      end
    end else if (cnt_inc >= ctl_i.period) begin
      cnt_d = '0;
      if (phase_q >= PH_DATA0 && phase_q <= PH_DLAST) shift_d = shift_q >> 1;
      phase_d = (phase_inc > PH_STOP) ? PH_IDLE : phase_inc;
    end else begin
      cnt_d = cnt_inc;
    end
  end

  // Line level from the updated phase
  always_comb begin
    if (phase_d == PH_IDLE || phase_d >= PH_STOP) tx_line_o = 1'b1;
    else if (phase_d == PH_START)                 tx_line_o = 1'b0;
    else                                          tx_line_o = shift_d[0];
  end
  assign tx_busy_o = (phase_d != PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/uabt_rx.sv */
module uabt_rx #(
  parameter int unsigned DATA_BITS = uabt_pkg::DATA_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  uabt_pkg::baud_ctl_t         ctl_i,
  input  logic                        rx_line_i,
  output logic                        rx_valid_o,
  output logic [uabt_pkg::BYTE_W-1:0] rx_byte_o
);

  localparam int unsigned PW = $clog2(DATA_BITS + 2);
  localparam logic [PW-1:0] PH_IDLE  = PW'(0);
  localparam logic [PW-1:0] PH_HALF  = PW'(1);
  localparam logic [PW-1:0] PH_DATA0 = PW'(2);
  localparam logic [PW-1:0] PH_DLAST = PW'(DATA_BITS + 1);

  logic [PW-1:0]                 phase_q, phase_d;
  logic [uabt_pkg::BYTE_W-1:0]   shift_q, shift_d, shift_in;
  logic [uabt_pkg::PERIOD_W-1:0] cnt_q, cnt_d, cnt_inc;

  assign cnt_inc  = cnt_q + 1'b1;
  // New bit enters at the MSB of the data field
  assign shift_in = (shift_q >> 1) |
                    (uabt_pkg::BYTE_W'(rx_line_i) << (DATA_BITS - 1));

  // Receive sequencer: wait for low, half period, then data bits; held idle while a measurement is busy
  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;
    rx_valid_o = 1'b0;
    rx_byte_o  = '0;
    if (ctl_i.meas_busy) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
    end else if (phase_q == PH_IDLE) begin
      if (!rx_line_i) begin
        phase_d = PH_HALF;
        cnt_d   = '0;
        shift_d = '0;
      end
    end else if (phase_q == PH_HALF) begin
      if (cnt_inc >= ctl_i.half) begin
        phase_d = PH_DATA0;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (cnt_inc >= ctl_i.period) begin
      cnt_d   = '0;
      shift_d = shift_in;
      if (phase_q >= PH_DLAST) begin
        phase_d    = PH_IDLE;
        rx_valid_o = 1'b1;
        rx_byte_o  = shift_in;
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end else begin
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
